// File: rtl/core/temperature_reading_spike_filter_assert.svh
// assertion macros for the spike filter
`ifndef TEMPERATURE_READING_SPIKE_FILTER_ASSERT_SVH
`define TEMPERATURE_READING_SPIKE_FILTER_ASSERT_SVH
`ifndef SYNTH
// consequent checked in the same cycle
`define TRSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spike filter check failed");
// consequent checked in the next cycle
`define TRSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spike filter check failed");
`else
`define TRSF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TRSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/trsf_pkg.sv
package trsf_pkg;

    localparam int unsigned TEMP_W    = 15;
    localparam int unsigned RAW_W     = 16;
    localparam int unsigned ROM_W     = 64;
    localparam int unsigned CLOSE_W   = 8;
    localparam int unsigned PERSIST_W = 10;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 10;

    localparam logic [CLOSE_W-1:0]   CLOSE_RST   = 8'd1;
    localparam logic [PERSIST_W-1:0] PERSIST_RST = 10'd100;

    localparam logic [7:0] FAMILY_A = 8'h10;
    localparam logic [7:0] FAMILY_B = 8'h28;
    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLOSE_LIMIT   = 2'd0,
        REG_PERSIST_LIMIT = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SENSOR  = 2'd1,
        ST_CRC_BAD    = 2'd2,
        ST_BAD_FAMILY = 2'd3
    } t_status;

    typedef struct packed {
        logic                    device_found;
        logic [ROM_W-1:0]        rom_code;
        logic signed [RAW_W-1:0] raw_temp;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic              has_value;
        logic [TEMP_W-1:0] filtered_temp;
    } t_out_item;

    // reflected crc8, lsb first over the seven low bytes
    function automatic logic [7:0] rom_crc8(input logic [ROM_W-1:0] rom);
        logic [7:0] crc;
        logic       mix;
        crc = 8'h00;
        for (int i = 0; i < 56; i++) begin
            mix = crc[0] ^ rom[i];
            crc = {1'b0, crc[7:1]} ^ (mix ? CRC_POLY : 8'h00);
        end
        return crc;
    endfunction

    function automatic logic [TEMP_W-1:0] abs_diff(input logic [TEMP_W-1:0] a,
                                                   input logic [TEMP_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// File: rtl/core/temperature_reading_spike_filter.sv
// Spike filter for sensor polls. Each item carries a found flag, the ROM code and the raw
// reading; the ROM code is CRC8 checked and its family byte screened, and a good positive
// reading close to the held temperature replaces it, while a far one must persist past the
// limit before it does. One item is taken every cycle while the output is not stalled; an
// item passes an input register and the result register, where its result waits until the
// output is taken. The filter state is updated in the same cycle an item moves from the
// input register to the result register. Configuration writes take effect on the next item
// processed.
module temperature_reading_spike_filter
    import trsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    `include "temperature_reading_spike_filter_assert.svh"

    logic                 r_in_vld;
    t_in_item             r_in;
    logic                 r_out_vld;
    t_out_item            r_out;

    logic [CLOSE_W-1:0]   r_close_limit;
    logic [PERSIST_W-1:0] r_persist_limit;

    logic                 r_held_vld;
    logic [TEMP_W-1:0]    r_held_temp;
    logic [TEMP_W-1:0]    r_cand_temp;
    logic [PERSIST_W-1:0] r_count;

    logic                 n_held_vld;
    logic [TEMP_W-1:0]    n_held_temp;
    logic [TEMP_W-1:0]    n_cand_temp;
    logic [PERSIST_W-1:0] n_count;
    t_status              w_status;

    logic                 w_adv;
    logic [TEMP_W-1:0]    w_reading;
    logic                 w_positive;
    logic [TEMP_W-1:0]    w_diff;
    logic [TEMP_W-1:0]    w_cand_diff;
    logic [PERSIST_W:0]   w_count_inc;
    logic [7:0]           w_family;

    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close_limit   <= CLOSE_RST;
            r_persist_limit <= PERSIST_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_CLOSE_LIMIT) begin
                r_close_limit <= i_cfg_data[CLOSE_W-1:0];
            end else if (i_cfg_idx == REG_PERSIST_LIMIT) begin
                r_persist_limit <= i_cfg_data[PERSIST_W-1:0];
            end
        end
    end

    assign w_family    = r_in.rom_code[7:0];
    assign w_reading   = r_in.raw_temp[TEMP_W-1:0];
    assign w_positive  = !r_in.raw_temp[RAW_W-1] && (r_in.raw_temp != '0);
    assign w_diff      = abs_diff(r_held_temp, w_reading);
    assign w_cand_diff = abs_diff(r_held_temp, r_cand_temp);
    assign w_count_inc = {1'b0, r_count} + {{PERSIST_W{1'b0}}, 1'b1};

    always_comb begin
        n_held_vld  = r_held_vld;
        n_held_temp = r_held_temp;
        n_cand_temp = r_cand_temp;
        n_count     = r_count;
        if (!r_in.device_found) begin
            w_status = ST_NO_SENSOR;
        end else if (rom_crc8(r_in.rom_code) != r_in.rom_code[ROM_W-1:ROM_W-8]) begin
            w_status = ST_CRC_BAD;
        end else if (w_family != FAMILY_A && w_family != FAMILY_B) begin
            w_status = ST_BAD_FAMILY;
        end else begin
            w_status = ST_OK;
            if (w_positive) begin
                if (!r_held_vld || (w_diff < {{(TEMP_W-CLOSE_W){1'b0}}, r_close_limit})) begin
                    n_count     = '0;
                    n_held_temp = w_reading;
                    n_held_vld  = 1'b1;
                end else begin
                    if (w_diff < w_cand_diff || r_count == '0) begin
                        n_cand_temp = w_reading;
                    end
                    // candidate wins once the count passes the limit
                    if (w_count_inc > {1'b0, r_persist_limit}) begin
                        n_count     = '0;
                        n_held_temp = n_cand_temp;
                    end else begin
                        n_count = w_count_inc[PERSIST_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_vld  <= 1'b0;
            r_held_temp <= '0;
            r_cand_temp <= '0;
            r_count     <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (w_adv) begin
                r_held_vld  <= n_held_vld;
                r_held_temp <= n_held_temp;
                r_cand_temp <= n_cand_temp;
                r_count     <= n_count;
                r_out_vld   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (w_adv) begin
            r_out.status        <= w_status;
            r_out.has_value     <= n_held_vld;
            r_out.filtered_temp <= n_held_vld ? n_held_temp : '0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    `TRSF_ASSERT_NEXT(a_held_sticks, i_clk, i_rst_n, r_held_vld, r_held_vld)
    `TRSF_ASSERT_NEXT(a_fail_keeps_state, i_clk, i_rst_n, w_adv && w_status != ST_OK,
        $stable(r_held_temp) && $stable(r_cand_temp) && $stable(r_count))
    `TRSF_ASSERT_NOW(a_empty_reads_zero, i_clk, i_rst_n,
        r_out_vld && !r_out.has_value, r_out.filtered_temp == '0)
    `TRSF_ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, w_adv, r_out_vld)

endmodule
